>>> rtl/core/csra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csra_pkg: shared definitions for the contiguous slot run allocator
// Pool geometry, command and status codes, sequencer states and helpers.
// ----------------------------------------------------------------------------
package csra_pkg;

	localparam int NUM_PAGES      = 16;
	localparam int SLOTS_PER_PAGE = 32;

	localparam int PAGE_W   = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int SLOT_W   = $clog2(SLOTS_PER_PAGE);
	localparam int PTR_W    = PAGE_W + 1;
	localparam int CHUNK_W  = 8;
	localparam int NCHUNK   = (SLOTS_PER_PAGE + CHUNK_W - 1) / CHUNK_W;
	localparam int CHUNK_IW = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
	localparam int TAKEN_W  = $clog2(SLOTS_PER_PAGE + 1);

	// field widths
	localparam int LEN_W   = 6;
	localparam int ADDR_W  = 9;
	localparam int STAT_W  = 3;
	localparam int USED_W  = 10;
	localparam int PAGES_W = 5;
	localparam int LIMIT_W = 5;

	// commands
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// status codes
	localparam logic [STAT_W-1:0] STS_OK        = 3'd0;
	localparam logic [STAT_W-1:0] STS_BAD_LEN   = 3'd1;
	localparam logic [STAT_W-1:0] STS_EXHAUSTED = 3'd2;
	localparam logic [STAT_W-1:0] STS_OUTSIDE   = 3'd3;
	localparam logic [STAT_W-1:0] STS_CROSS     = 3'd4;

	// register map
	localparam logic REG_PAGE_LIMIT = 1'b0;
	localparam logic [LIMIT_W-1:0] PAGE_LIMIT_RST = 5'd16;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_FREE,
		S_COUNT,
		S_DONE
	} state_t;

	// len ones starting at bit pos; len in 1..SLOTS_PER_PAGE
	function automatic logic [SLOTS_PER_PAGE-1:0] run_mask(
		input logic [LEN_W-1:0]  len,
		input logic [SLOT_W-1:0] pos
	);
		logic [SLOTS_PER_PAGE:0] ones;
		ones = ({{SLOTS_PER_PAGE{1'b0}}, 1'b1} << len) - 1'b1;
		return ones[SLOTS_PER_PAGE-1:0] << pos;
	endfunction

	function automatic logic [3:0] pop8(input logic [CHUNK_W-1:0] v);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < CHUNK_W; i++) begin
			n = n + 4'(v[i]);
		end
		return n;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/contiguous_slot_run_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// contiguous_slot_run_allocator_unit: first-fit contiguous slot run allocator
// Keeps a free bitmap per page, serves alloc and free requests one at a time.
// ----------------------------------------------------------------------------
// channel   signals                               direction
// req       req_valid/req_ready, cmd, run_length, free_start    in
// rsp       rsp_valid/rsp_ready, status, run_start, page_added,
//           slots_used, pages_used                              out
// cfg       APB: psel penable pwrite paddr pwdata prdata pready  in/out
//
// Alloc: the scan checks one page bitmap word per cycle; when no page in use
// fits, a further scan step adds a page or reports exhaustion.
// Free: the released slot count is summed 8 bits per cycle.
// Reset clears counts and state; bitmap words are written when a page opens.
// A stalled response holds the unit in its final state until taken.
// ----------------------------------------------------------------------------
module contiguous_slot_run_allocator_unit
	import csra_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	// request
	input  wire                   req_valid,
	output logic                  req_ready,
	input  wire                   cmd,
	input  wire  [LEN_W-1:0]      run_length,
	input  wire  [ADDR_W-1:0]     free_start,
	// response
	output logic                  rsp_valid,
	input  wire                   rsp_ready,
	output logic [STAT_W-1:0]     status,
	output logic [ADDR_W-1:0]     run_start,
	output logic                  page_added,
	output logic [USED_W-1:0]     slots_used,
	output logic [PAGES_W-1:0]    pages_used,
	// configuration
	input  wire                   psel,
	input  wire                   penable,
	input  wire                   pwrite,
	input  wire  [2:0]            paddr,
	input  wire  [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	state_t state_q, state_d;

	logic                      cmd_q;
	logic [LEN_W-1:0]          len_q;
	logic [ADDR_W-1:0]         fstart_q;
	logic [PTR_W-1:0]          ptr_q;
	logic [SLOTS_PER_PAGE-1:0] map_q [NUM_PAGES];
	logic [PAGES_W-1:0]        page_count_q;
	logic [USED_W-1:0]         used_count_q;
	logic [LIMIT_W-1:0]        page_limit_q;

	logic [STAT_W-1:0]         res_status_q;
	logic [ADDR_W-1:0]         res_start_q;
	logic                      res_added_q;

	logic [NCHUNK*CHUNK_W-1:0] bits_q;
	logic [CHUNK_IW-1:0]       chunk_q;
	logic [TAKEN_W-1:0]        taken_q;

	// control decodes
	logic                      accept;
	logic                      cfg_wr;
	logic                      rsp_load;

	// datapath
	logic                      bad_len;
	logic [PAGE_W-1:0]         free_page;
	logic [SLOT_W-1:0]         free_slot;
	logic                      free_outside;
	logic                      free_cross;
	logic [PAGE_W-1:0]         rd_page;
	logic [SLOTS_PER_PAGE-1:0] word_rd;
	logic [SLOTS_PER_PAGE-1:0] free_mask;
	logic [SLOTS_PER_PAGE-1:0] fit;
	logic                      fit_any;
	logic [SLOT_W-1:0]         fit_pos;
	logic [SLOTS_PER_PAGE-1:0] fit_mask;
	logic                      ptr_in_use;
	logic                      ptr_last;
	logic [LIMIT_W-1:0]        limit;
	logic                      can_add;
	logic [TAKEN_W-1:0]        taken_next;
	logic                      chunk_last;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		prdata = '0;
		if (paddr == {REG_PAGE_LIMIT, 2'b00}) begin
			prdata[LIMIT_W-1:0] = page_limit_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_limit_q <= PAGE_LIMIT_RST;
		end else if (cfg_wr && paddr == {REG_PAGE_LIMIT, 2'b00}) begin
			page_limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	// ---------------- datapath decodes ----------------
	assign bad_len   = (len_q == '0) || (len_q > LEN_W'(SLOTS_PER_PAGE));
	assign free_page = PAGE_W'(fstart_q / SLOTS_PER_PAGE);
	assign free_slot = SLOT_W'(fstart_q % SLOTS_PER_PAGE);
	assign free_outside = ({1'b0, free_page} >= PTR_W'(page_count_q));
	assign free_cross   = (LEN_W'(free_slot) + len_q) > LEN_W'(SLOTS_PER_PAGE);

	assign rd_page = (state_q == S_FREE) ? free_page : ptr_q[PAGE_W-1:0];
	assign word_rd = map_q[rd_page];
	assign free_mask = run_mask(len_q, free_slot);

	// all window positions checked side by side, lowest fit wins
	always_comb begin
		for (int s = 0; s < SLOTS_PER_PAGE; s++) begin
			fit[s] = ((s + int'(len_q)) <= SLOTS_PER_PAGE) &&
				((word_rd & run_mask(len_q, SLOT_W'(s))) == run_mask(len_q, SLOT_W'(s)));
		end
	end

	always_comb begin
		fit_pos = '0;
		for (int s = SLOTS_PER_PAGE - 1; s >= 0; s--) begin
			if (fit[s]) begin
				fit_pos = SLOT_W'(s);
			end
		end
	end

	assign fit_any    = |fit;
	assign fit_mask   = run_mask(len_q, fit_pos);
	assign ptr_in_use = (ptr_q < PTR_W'(page_count_q));
	assign ptr_last   = ((ptr_q + 1'b1) >= PTR_W'(page_count_q));
	assign limit      = (page_limit_q > LIMIT_W'(NUM_PAGES)) ? LIMIT_W'(NUM_PAGES) :
		page_limit_q;
	assign can_add    = (page_count_q < PAGES_W'(limit));

	assign taken_next = taken_q + TAKEN_W'(pop8(bits_q[CHUNK_W-1:0]));
	assign chunk_last = (chunk_q == CHUNK_IW'(NCHUNK - 1));

	// ---------------- sequencer ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (bad_len) begin
					state_d = S_DONE;
				end else if (cmd_q == CMD_ALLOC) begin
					state_d = S_SCAN;
				end else if (free_outside || free_cross) begin
					state_d = S_DONE;
				end else begin
					state_d = S_FREE;
				end
			end
			S_SCAN: begin
				if (!ptr_in_use || fit_any || ptr_last) begin
					// a miss on the last page still needs the add step
					if (!ptr_in_use || fit_any) state_d = S_DONE;
				end
			end
			S_FREE:  state_d = S_COUNT;
			S_COUNT: begin
				if (chunk_last) state_d = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid || rsp_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready = (state_q == S_IDLE);
		accept    = req_valid && req_ready;
		rsp_load  = (state_q == S_DONE) && (!rsp_valid || rsp_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd;
			len_q    <= run_length;
			fstart_q <= free_start;
		end
	end

	// scan pointer, result fields and pool state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			page_count_q <= '0;
			used_count_q <= '0;
			res_status_q <= STS_OK;
			res_start_q  <= '0;
			res_added_q  <= 1'b0;
			chunk_q      <= '0;
			taken_q      <= '0;
		end else begin
			case (state_q)
				S_CHECK: begin
					ptr_q        <= '0;
					chunk_q      <= '0;
					taken_q      <= '0;
					res_start_q  <= '0;
					res_added_q  <= 1'b0;
					if (bad_len) begin
						res_status_q <= STS_BAD_LEN;
					end else if (cmd_q == CMD_FREE && free_outside) begin
						res_status_q <= STS_OUTSIDE;
					end else if (cmd_q == CMD_FREE && free_cross) begin
						res_status_q <= STS_CROSS;
					end else begin
						res_status_q <= STS_OK;
					end
				end
				S_SCAN: begin
					if (ptr_in_use) begin
						if (fit_any) begin
							res_start_q  <= ADDR_W'(int'(ptr_q) * SLOTS_PER_PAGE + int'(fit_pos));
							used_count_q <= used_count_q + USED_W'(len_q);
						end else begin
							ptr_q <= ptr_q + 1'b1;
						end
					end else if (can_add) begin
						res_start_q  <= ADDR_W'(int'(page_count_q) * SLOTS_PER_PAGE);
						res_added_q  <= 1'b1;
						page_count_q <= page_count_q + 1'b1;
						used_count_q <= used_count_q + USED_W'(len_q);
					end else begin
						res_status_q <= STS_EXHAUSTED;
					end
				end
				S_COUNT: begin
					chunk_q <= chunk_q + 1'b1;
					taken_q <= taken_next;
					if (chunk_last) begin
						used_count_q <= (USED_W'(taken_next) <= used_count_q) ?
							used_count_q - USED_W'(taken_next) : '0;
					end
				end
				default: ;
			endcase
		end
	end

	// bitmap words: written when a page opens, on a fit, and on a free
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN) begin
			if (ptr_in_use && fit_any) begin
				map_q[ptr_q[PAGE_W-1:0]] <= word_rd & ~fit_mask;
			end else if (!ptr_in_use && can_add) begin
				map_q[page_count_q[PAGE_W-1:0]] <= ~run_mask(len_q, '0);
			end
		end else if (state_q == S_FREE) begin
			map_q[free_page] <= word_rd | free_mask;
		end
	end

	// slots being released that were allocated, summed a byte at a time
	always_ff @(posedge clk) begin
		if (state_q == S_FREE) begin
			bits_q <= (NCHUNK*CHUNK_W)'(free_mask & ~word_rd);
		end else if (state_q == S_COUNT) begin
			bits_q <= bits_q >> CHUNK_W;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			status     <= res_status_q;
			run_start  <= res_start_q;
			page_added <= res_added_q;
			slots_used <= used_count_q;
			pages_used <= page_count_q;
		end
	end

endmodule
`default_nettype wire

>>> test/contiguous_slot_run_allocator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_slot_run_allocator_unit_tb: self-checking bench for the allocator
// Walks a directed request table, then random alloc/free traffic under several
// page limits. Typed rows check listed values, others the in-bench first-fit model.
// ----------------------------------------------------------------------------
module contiguous_slot_run_allocator_unit_tb;
	import csra_pkg::*;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [ADDR_W-1:0]  start;
		logic               added;
		logic [USED_W-1:0]  used;
		logic [PAGES_W-1:0] pages;
	} outcome_t;

	typedef struct packed {
		logic              c;
		logic [LEN_W-1:0]  len;
		logic [ADDR_W-1:0] fs;
		logic              typed;
		outcome_t          want;
	} row_t;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [LEN_W-1:0]  len;
	} run_t;

	localparam int NUM_ROWS   = 20;
	localparam int NUM_PHASES = 7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  req_valid = 1'b0;
	logic                  req_ready;
	logic                  cmd = 1'b0;
	logic [LEN_W-1:0]      run_length = '0;
	logic [ADDR_W-1:0]     free_start = '0;
	logic                  rsp_valid;
	logic                  rsp_ready = 1'b0;
	logic [STAT_W-1:0]     status;
	logic [ADDR_W-1:0]     run_start;
	logic                  page_added;
	logic [USED_W-1:0]     slots_used;
	logic [PAGES_W-1:0]    pages_used;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [2:0]            paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;

	// allocator image: one free bit per slot
	logic [SLOTS_PER_PAGE-1:0] free_bits [NUM_PAGES];
	int                        open_pages;
	int                        taken_slots;
	int                        page_cap;

	outcome_t pending_outcomes [$];
	run_t     live_runs [$];
	row_t     plan [NUM_ROWS];
	bit       idling = 1'b1;
	int       mismatches = 0;
	int       requests_sent = 0;
	int       status_seen [5] = '{0, 0, 0, 0, 0};

	int phase_limit [NUM_PHASES] = '{0, 2, 5, 31, 1, 16, 9};
	int phase_items [NUM_PHASES] = '{30, 110, 110, 140, 90, 150, 60};
	bit phase_idle  [NUM_PHASES] = '{1, 1, 1, 0, 1, 0, 1};

	contiguous_slot_run_allocator_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.cmd        (cmd),
		.run_length (run_length),
		.free_start (free_start),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.status     (status),
		.run_start  (run_start),
		.page_added (page_added),
		.slots_used (slots_used),
		.pages_used (pages_used),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #6 clk = ~clk;

	function automatic logic [SLOTS_PER_PAGE-1:0] span_bits(input int len, input int pos);
		logic [63:0] w;
		w = ((64'd1 << len) - 64'd1) << pos;
		return w[SLOTS_PER_PAGE-1:0];
	endfunction

	// first-fit allocate / free, updates the image and returns the response
	function automatic outcome_t serve_request(input logic c, input logic [LEN_W-1:0] len,
			input logic [ADDR_W-1:0] fs);
		outcome_t o;
		logic [SLOTS_PER_PAGE-1:0] m;
		int cap, pg, sl, cnt;
		bit hit;
		o = '0;
		hit = 1'b0;
		if (len == 0 || len > SLOTS_PER_PAGE) begin
			o.status = STS_BAD_LEN;
		end else if (c == CMD_ALLOC) begin
			cap = (page_cap < NUM_PAGES) ? page_cap : NUM_PAGES;
			for (pg = 0; pg < open_pages && !hit; pg++) begin
				for (sl = 0; sl + len <= SLOTS_PER_PAGE && !hit; sl++) begin
					m = span_bits(len, sl);
					if ((free_bits[pg] & m) == m) begin
						free_bits[pg] &= ~m;
						o.start = ADDR_W'(pg * SLOTS_PER_PAGE + sl);
						hit = 1'b1;
					end
				end
			end
			if (!hit) begin
				if (open_pages < cap) begin
					free_bits[open_pages] = ~span_bits(len, 0);
					o.start = ADDR_W'(open_pages * SLOTS_PER_PAGE);
					o.added = 1'b1;
					open_pages++;
					hit = 1'b1;
				end else begin
					o.status = STS_EXHAUSTED;
				end
			end
			if (hit)
				taken_slots += len;
		end else begin
			pg = fs / SLOTS_PER_PAGE;
			sl = fs % SLOTS_PER_PAGE;
			if (pg >= open_pages) begin
				o.status = STS_OUTSIDE;
			end else if (sl + len > SLOTS_PER_PAGE) begin
				o.status = STS_CROSS;
			end else begin
				// double free: only slots still allocated come back
				m = span_bits(len, sl);
				cnt = $countones(m & ~free_bits[pg]);
				free_bits[pg] |= m;
				taken_slots -= (cnt <= taken_slots) ? cnt : taken_slots;
			end
		end
		o.used  = USED_W'(taken_slots);
		o.pages = PAGES_W'(open_pages);
		return o;
	endfunction

	function automatic row_t mk_row(input logic c, input int len, input int fs, input logic typed,
			input logic [STAT_W-1:0] st, input int start, input logic added,
			input int used, input int pages);
		row_t r;
		r.c = c;
		r.len = LEN_W'(len);
		r.fs = ADDR_W'(fs);
		r.typed = typed;
		r.want.status = st;
		r.want.start = ADDR_W'(start);
		r.want.added = added;
		r.want.used = USED_W'(used);
		r.want.pages = PAGES_W'(pages);
		return r;
	endfunction

	task automatic push_request(input logic c, input logic [LEN_W-1:0] len,
			input logic [ADDR_W-1:0] fs, input logic typed, input outcome_t want);
		int gap;
		outcome_t got;
		gap = idling ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid  <= 1'b1;
		cmd        <= c;
		run_length <= len;
		free_start <= fs;
		do @(posedge clk); while (!req_ready);
		got = serve_request(c, len, fs);
		pending_outcomes.push_back(typed ? want : got);
		if (c == CMD_ALLOC && got.status == STS_OK)
			live_runs.push_back({got.start, len});
		requests_sent++;
	endtask

	task automatic random_request();
		logic c;
		logic [LEN_W-1:0] len;
		logic [ADDR_W-1:0] fs;
		run_t pick;
		int k, r;
		r = $urandom_range(0, 99);
		if (r < 4)
			len = '0;
		else if (r < 8)
			len = LEN_W'($urandom_range(33, 63));
		else if (r < 22)
			len = LEN_W'($urandom_range(9, 32));
		else
			len = LEN_W'($urandom_range(1, 8));
		fs = ADDR_W'($urandom_range(0, 511));
		c = ($urandom_range(0, 99) < 55) ? CMD_ALLOC : CMD_FREE;
		// most frees return a run that is actually out; some overlap its edges
		if (c == CMD_FREE && live_runs.size() > 0 && $urandom_range(0, 99) < 75) begin
			k = $urandom_range(0, live_runs.size() - 1);
			pick = live_runs[k];
			live_runs.delete(k);
			fs = pick.start;
			len = pick.len;
			if ($urandom_range(0, 99) < 20) begin
				fs = fs + ADDR_W'($urandom_range(0, 2));
				len = len + LEN_W'($urandom_range(0, 3));
			end
		end
		push_request(c, len, fs, 1'b0, '0);
	endtask

	task automatic reg_access(input logic wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {REG_PAGE_LIMIT, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_limit_reg();
		logic [31:0] rd;
		reg_access(1'b0, 32'd0, rd);
		if (rd !== 32'(page_cap)) begin
			$error("page_limit readback: expected %0d, got %0d", page_cap, rd);
			mismatches++;
		end
	endtask

	task automatic set_limit(input int value);
		logic [31:0] unused_rd;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		reg_access(1'b1, 32'(value), unused_rd);
		page_cap = value & 32'h1F;
		check_limit_reg();
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// response side
	initial begin
		int stall;
		outcome_t w;
		@(posedge arst_n);
		forever begin
			stall = idling ? $urandom_range(0, 16) : 0;
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			if (status <= STS_CROSS)
				status_seen[status]++;
			if (pending_outcomes.size() == 0) begin
				$error("response with no request outstanding (status %0d)", status);
				mismatches++;
			end else begin
				w = pending_outcomes.pop_front();
				check_field("status", w.status, status);
				check_field("run_start", w.start, run_start);
				check_field("page_added", w.added, page_added);
				check_field("slots_used", w.used, slots_used);
				check_field("pages_used", w.pages, pages_used);
			end
		end
	end

	// stimulus
	initial begin
		for (int p = 0; p < NUM_PAGES; p++)
			free_bits[p] = '1;
		open_pages  = 0;
		taken_slots = 0;
		page_cap    = PAGE_LIMIT_RST;

		plan[0]  = mk_row(CMD_ALLOC, 0, 0, 1, STS_BAD_LEN, 0, 0, 0, 0);
		plan[1]  = mk_row(CMD_ALLOC, 33, 0, 1, STS_BAD_LEN, 0, 0, 0, 0);
		plan[2]  = mk_row(CMD_ALLOC, 63, 511, 1, STS_BAD_LEN, 0, 0, 0, 0);
		plan[3]  = mk_row(CMD_FREE, 0, 0, 1, STS_BAD_LEN, 0, 0, 0, 0);
		plan[4]  = mk_row(CMD_FREE, 1, 0, 1, STS_OUTSIDE, 0, 0, 0, 0);
		plan[5]  = mk_row(CMD_ALLOC, 32, 0, 1, STS_OK, 0, 1, 32, 1);
		plan[6]  = mk_row(CMD_ALLOC, 1, 0, 1, STS_OK, 32, 1, 33, 2);
		plan[7]  = mk_row(CMD_ALLOC, 31, 0, 1, STS_OK, 33, 0, 64, 2);
		plan[8]  = mk_row(CMD_FREE, 1, 511, 1, STS_OUTSIDE, 0, 0, 64, 2);
		plan[9]  = mk_row(CMD_FREE, 2, 31, 1, STS_CROSS, 0, 0, 64, 2);
		plan[10] = mk_row(CMD_FREE, 3, 5, 0, STS_OK, 0, 0, 0, 0);
		plan[11] = mk_row(CMD_FREE, 5, 4, 0, STS_OK, 0, 0, 0, 0);   // partly free already
		plan[12] = mk_row(CMD_ALLOC, 4, 0, 0, STS_OK, 0, 0, 0, 0);
		plan[13] = mk_row(CMD_ALLOC, 1, 0, 0, STS_OK, 0, 0, 0, 0);
		plan[14] = mk_row(CMD_FREE, 32, 32, 0, STS_OK, 0, 0, 0, 0);
		plan[15] = mk_row(CMD_ALLOC, 32, 0, 0, STS_OK, 0, 0, 0, 0);
		plan[16] = mk_row(CMD_FREE, 32, 0, 0, STS_OK, 0, 0, 0, 0);
		plan[17] = mk_row(CMD_ALLOC, 32, 511, 0, STS_OK, 0, 0, 0, 0);
		plan[18] = mk_row(CMD_FREE, 1, 32, 0, STS_OK, 0, 0, 0, 0);
		plan[19] = mk_row(CMD_ALLOC, 1, 0, 0, STS_OK, 0, 0, 0, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		check_limit_reg();

		for (int i = 0; i < NUM_ROWS; i++)
			push_request(plan[i].c, plan[i].len, plan[i].fs, plan[i].typed, plan[i].want);
		req_valid <= 1'b0;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			set_limit(phase_limit[ph]);
			idling = phase_idle[ph];
			for (int n = 0; n < phase_items[ph]; n++)
				random_request();
			req_valid <= 1'b0;
		end

		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);

		$display("Sent %0d requests over %0d page-limit settings, %0d of %0d pages opened",
			requests_sent, NUM_PHASES, open_pages, NUM_PAGES);
		$display("Responses by status: ok %0d, bad length %0d, exhausted %0d, outside %0d, crossing %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d responses outstanding", pending_outcomes.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/csra_pkg.sv
rtl/core/contiguous_slot_run_allocator_unit.sv
test/contiguous_slot_run_allocator_unit_tb.sv
